>>> design/half_bit_timing_statistics_unit_macros.svh
// Assertion macros shared by the half-bit timing statistics design.
`ifndef HALF_BIT_TIMING_STATISTICS_UNIT_MACROS_SVH
`define HALF_BIT_TIMING_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HBTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HBTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hbts_pkg.sv
// Shared constants, types and codes of the half-bit timing statistics unit.
package hbts_pkg;

  localparam int BINS     = 128;
  localparam int BIN_W    = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 32;
  localparam int KIND_W   = 2;
  localparam int BSEL_W   = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BIN_W-1:0]  bin_addr_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [BSEL_W-1:0] bsel_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam len_t LOW_RESET     = 16'hFFFF;
  localparam len_t LOWEST_RESET  = 16'd45;
  localparam len_t HIGHEST_RESET = 16'd150;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD   = 2'd0,
    KIND_READ     = 2'd1,
    KIND_SNAPSHOT = 2'd2
  } kind_e;

  typedef enum logic {
    REG_LOWEST  = 1'b0,
    REG_HIGHEST = 1'b1
  } reg_e;

  typedef struct packed {
    cnt_t second_cnt;
    cnt_t first_cnt;
  } bin_pair_t;

  typedef struct packed {
    logic      rd_en;
    bin_addr_t rd_addr;
    logic      upd_en;
    logic      upd_half;
    logic      clr_en;
    bin_addr_t clr_addr;
  } hist_ctrl_t;

  typedef struct packed {
    logic rec_en;
    logic clr_en;
    logic second_half;
    logic bit_value;
    len_t half_length;
    len_t half_delta;
  } sum_ctrl_t;

  typedef struct packed {
    cnt_t zero_count;
    cnt_t one_count;
    len_t zero_min;
    len_t zero_max;
    cnt_t zero_total;
    len_t zero_delta_peak;
    len_t one_min;
    len_t one_max;
    cnt_t one_total;
    len_t one_delta_peak;
  } summary_t;

endpackage

>>> design/hbts_ifs.sv
// Request and result channel interfaces of the half-bit timing statistics unit.
interface hbts_req_if;
  logic                 valid;
  logic                 ready;
  hbts_pkg::kind_t      kind;
  logic                 second_half;
  logic                 bit_value;
  hbts_pkg::len_t       half_length;
  hbts_pkg::len_t       half_delta;
  hbts_pkg::bsel_t      bin_index;

  modport source (output valid, kind, second_half, bit_value, half_length, half_delta,
                  bin_index, input ready);
  modport sink (input valid, kind, second_half, bit_value, half_length, half_delta,
                bin_index, output ready);
endinterface

interface hbts_res_if;
  logic           valid;
  logic           ready;
  hbts_pkg::cnt_t zero_count;
  hbts_pkg::cnt_t one_count;
  hbts_pkg::len_t zero_min;
  hbts_pkg::len_t zero_max;
  hbts_pkg::cnt_t zero_total;
  hbts_pkg::len_t zero_delta_peak;
  hbts_pkg::len_t one_min;
  hbts_pkg::len_t one_max;
  hbts_pkg::cnt_t one_total;
  hbts_pkg::len_t one_delta_peak;
  hbts_pkg::cnt_t first_half_bin;
  hbts_pkg::cnt_t second_half_bin;

  modport source (output valid, zero_count, one_count, zero_min, zero_max, zero_total,
                  zero_delta_peak, one_min, one_max, one_total, one_delta_peak,
                  first_half_bin, second_half_bin, input ready);
  modport sink (input valid, zero_count, one_count, zero_min, zero_max, zero_total,
                zero_delta_peak, one_min, one_max, one_total, one_delta_peak,
                first_half_bin, second_half_bin, output ready);
endinterface

>>> design/half_bit_timing_statistics_unit.sv
// Top level of the half-bit timing statistics unit: control, configuration and result register.
//
// Channel   Direction  Handshake     Contents
// req_i     in         valid/ready   kind, half flag, bit value, length, delta, bin index
// res_o     out        valid/ready   per-value summary and the histogram bin pair
// apb       in         psel/penable  lowest_length at 0x0, highest_length at 0x4
//
// Each request passes through ST_IDLE and ST_UPDATE: the histogram row is read on acceptance
// and written back or returned in ST_UPDATE, through the single memory port.
// After reset and after every snapshot the histogram is swept clear, one bin per cycle,
// across all BINS (128) bins, during which no request is accepted.
// A read or snapshot waits in ST_UPDATE while an earlier result is still held.
`include "half_bit_timing_statistics_unit_macros.svh"

module half_bit_timing_statistics_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  hbts_req_if.sink            req_i,
  hbts_res_if.source          res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  hbts_pkg::addr_t     paddr,
  input  hbts_pkg::data_t     pwdata,
  output hbts_pkg::data_t     prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  localparam hbts_pkg::bin_addr_t BinLast = hbts_pkg::bin_addr_t'(hbts_pkg::BINS - 1);

  state_e               state_q;
  hbts_pkg::bin_addr_t  clr_q;
  hbts_pkg::len_t       lowest_q;
  hbts_pkg::len_t       highest_q;
  hbts_pkg::kind_t      kind_q;
  logic                 half_q;
  logic                 bit_q;
  hbts_pkg::len_t       len_q;
  hbts_pkg::len_t       delta_q;
  logic                 oob_q;
  logic                 out_valid_q;
  hbts_pkg::summary_t   out_sum_q;
  hbts_pkg::bin_pair_t  out_bins_q;

  logic                 req_fire;
  logic                 res_free;
  logic                 res_load;
  logic                 is_query;
  logic                 cfg_write;
  logic                 sel_oob;
  hbts_pkg::len_t       sel_ext;
  hbts_pkg::bin_addr_t  rec_addr;
  hbts_pkg::hist_ctrl_t hist_ctrl;
  hbts_pkg::sum_ctrl_t  sum_ctrl;
  hbts_pkg::bin_pair_t  hist_rdata;
  hbts_pkg::summary_t   sum;

  function automatic hbts_pkg::bin_addr_t bin_of(input hbts_pkg::len_t len,
                                                 input hbts_pkg::len_t lo,
                                                 input hbts_pkg::len_t hi);
    hbts_pkg::len_t      c;
    hbts_pkg::len_t      idx;
    hbts_pkg::bin_addr_t r;
    c   = (len > hi) ? hi : len;
    idx = c - lo;
    if (len <= lo || c < lo) begin
      r = '0;
    end else if (idx > hbts_pkg::len_t'(hbts_pkg::BINS - 1)) begin
      r = hbts_pkg::bin_addr_t'(hbts_pkg::BINS - 1);
    end else begin
      r = idx[hbts_pkg::BIN_W-1:0];
    end
    return r;
  endfunction

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign res_free    = !out_valid_q || res_o.ready;
  assign is_query    = (kind_q == hbts_pkg::KIND_READ) || (kind_q == hbts_pkg::KIND_SNAPSHOT);
  assign res_load    = (state_q == ST_UPDATE) && is_query && res_free;

  assign sel_ext  = hbts_pkg::len_t'(req_i.bin_index);
  assign sel_oob  = sel_ext >= hbts_pkg::len_t'(hbts_pkg::BINS);
  assign rec_addr = bin_of(req_i.half_length, lowest_q, highest_q);

  always_comb begin
    hist_ctrl.rd_en    = req_fire;
    hist_ctrl.rd_addr  = (req_i.kind == hbts_pkg::KIND_RECORD) ? rec_addr
                                                               : sel_ext[hbts_pkg::BIN_W-1:0];
    hist_ctrl.upd_en   = (state_q == ST_UPDATE) && (kind_q == hbts_pkg::KIND_RECORD);
    hist_ctrl.upd_half = half_q;
    hist_ctrl.clr_en   = (state_q == ST_CLEAR);
    hist_ctrl.clr_addr = clr_q;
  end

  always_comb begin
    sum_ctrl.rec_en      = (state_q == ST_UPDATE) && (kind_q == hbts_pkg::KIND_RECORD);
    sum_ctrl.clr_en      = (state_q == ST_UPDATE) && (kind_q == hbts_pkg::KIND_SNAPSHOT)
                           && res_free;
    sum_ctrl.second_half = half_q;
    sum_ctrl.bit_value   = bit_q;
    sum_ctrl.half_length = len_q;
    sum_ctrl.half_delta  = delta_q;
  end

  hbts_hist u_hist (
    .clk_i   (clk_i),
    .ctrl_i  (hist_ctrl),
    .rdata_o (hist_rdata)
  );

  hbts_summary u_summary (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sum_ctrl),
    .sum_o  (sum)
  );

  // Configuration registers.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == hbts_pkg::REG_HIGHEST) ? hbts_pkg::data_t'(highest_q)
                                                         : hbts_pkg::data_t'(lowest_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= hbts_pkg::LOWEST_RESET;
      highest_q <= hbts_pkg::HIGHEST_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == hbts_pkg::REG_HIGHEST) begin
        highest_q <= pwdata[hbts_pkg::LEN_W-1:0];
      end else begin
        lowest_q <= pwdata[hbts_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q  <= req_i.kind;
      half_q  <= req_i.second_half;
      bit_q   <= req_i.bit_value;
      len_q   <= req_i.half_length;
      delta_q <= req_i.half_delta;
      oob_q   <= sel_oob;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
      out_bins_q  <= '0;
    end else begin
      out_valid_q <= res_load || (out_valid_q && !res_o.ready);
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BinLast) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (!is_query) begin
            state_q <= ST_IDLE;
          end else if (res_free) begin
            out_sum_q   <= sum;
            out_bins_q  <= oob_q ? '0 : hist_rdata;
            if (kind_q == hbts_pkg::KIND_SNAPSHOT) begin
              clr_q   <= '0;
              state_q <= ST_CLEAR;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_CLEAR;
          clr_q   <= '0;
        end
      endcase
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.zero_count      = out_sum_q.zero_count;
  assign res_o.one_count       = out_sum_q.one_count;
  assign res_o.zero_min        = out_sum_q.zero_min;
  assign res_o.zero_max        = out_sum_q.zero_max;
  assign res_o.zero_total      = out_sum_q.zero_total;
  assign res_o.zero_delta_peak = out_sum_q.zero_delta_peak;
  assign res_o.one_min         = out_sum_q.one_min;
  assign res_o.one_max         = out_sum_q.one_max;
  assign res_o.one_total       = out_sum_q.one_total;
  assign res_o.one_delta_peak  = out_sum_q.one_delta_peak;
  assign res_o.first_half_bin  = out_bins_q.first_cnt;
  assign res_o.second_half_bin = out_bins_q.second_cnt;

  `HBTS_ASSERT_NOW(a_no_request_in_clear, state_q == ST_CLEAR, !req_i.ready, "request taken during clear")
  `HBTS_ASSERT_NOW(a_single_mem_access, hist_ctrl.rd_en, !hist_ctrl.upd_en && !hist_ctrl.clr_en, "histogram read collides with a write")
  `HBTS_ASSERT_NEXT(a_snapshot_clears, sum_ctrl.clr_en, state_q == ST_CLEAR && clr_q == '0, "snapshot did not start the clear")
  `HBTS_ASSERT_NEXT(a_record_no_result, hist_ctrl.upd_en && !out_valid_q, !out_valid_q, "record request produced a result")

endmodule

>>> design/hbts_hist.sv
// Histogram memory with registered read, read-modify-write increment and clear port.
module hbts_hist (
  input  logic                  clk_i,
  input  hbts_pkg::hist_ctrl_t  ctrl_i,
  output hbts_pkg::bin_pair_t   rdata_o
);

  hbts_pkg::bin_pair_t mem [hbts_pkg::BINS];
  hbts_pkg::bin_pair_t rdata_q;
  hbts_pkg::bin_addr_t raddr_q;
  hbts_pkg::bin_pair_t upd_row;

  always_comb begin
    upd_row = rdata_q;
    if (ctrl_i.upd_half) begin
      upd_row.second_cnt = rdata_q.second_cnt + 32'd1;
    end else begin
      upd_row.first_cnt = rdata_q.first_cnt + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[ctrl_i.rd_addr];
      raddr_q <= ctrl_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_en) begin
      mem[ctrl_i.clr_addr] <= '0;
    end else if (ctrl_i.upd_en) begin
      mem[raddr_q] <= upd_row;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hbts_summary.sv
// Per-bit-value count, minimum, maximum, total and delta peak registers.
module hbts_summary (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hbts_pkg::sum_ctrl_t  ctrl_i,
  output hbts_pkg::summary_t   sum_o
);

  localparam hbts_pkg::summary_t SumInit = '{
    zero_min: hbts_pkg::LOW_RESET,
    one_min:  hbts_pkg::LOW_RESET,
    default:  '0
  };

  hbts_pkg::summary_t sum_q;
  hbts_pkg::summary_t sum_d;
  hbts_pkg::cnt_t     len_ext;

  always_comb begin
    len_ext                  = hbts_pkg::cnt_t'(ctrl_i.half_length);
    sum_d                    = sum_q;
    if (ctrl_i.clr_en) begin
      sum_d = SumInit;
    end else if (ctrl_i.rec_en) begin
      if (!ctrl_i.bit_value) begin
        sum_d.zero_count = sum_q.zero_count + 32'd1;
        sum_d.zero_total = sum_q.zero_total + len_ext;
        if (ctrl_i.half_length > sum_q.zero_max) sum_d.zero_max = ctrl_i.half_length;
        if (ctrl_i.half_length < sum_q.zero_min) sum_d.zero_min = ctrl_i.half_length;
        if (ctrl_i.second_half && ctrl_i.half_delta > sum_q.zero_delta_peak) begin
          sum_d.zero_delta_peak = ctrl_i.half_delta;
        end
      end else begin
        sum_d.one_count = sum_q.one_count + 32'd1;
        sum_d.one_total = sum_q.one_total + len_ext;
        if (ctrl_i.half_length > sum_q.one_max) sum_d.one_max = ctrl_i.half_length;
        if (ctrl_i.half_length < sum_q.one_min) sum_d.one_min = ctrl_i.half_length;
        if (ctrl_i.second_half && ctrl_i.half_delta > sum_q.one_delta_peak) begin
          sum_d.one_delta_peak = ctrl_i.half_delta;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= SumInit;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> dv/hbts_stats_compare.sv
// Predicts the statistics replies of the half-bit timing statistics unit and compares them.
module hbts_stats_compare
  import hbts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  hbts_req_if   req_i,
  hbts_res_if   res_i,
  input  logic  psel,
  input  logic  penable,
  input  logic  pwrite,
  input  addr_t paddr,
  input  data_t pwdata,
  input  logic  pready,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct {
    cnt_t tally;
    len_t low;
    len_t high;
    cnt_t sum;
    len_t delta_high;
  } value_stats_t;

  typedef struct packed {
    summary_t summary;
    cnt_t     first_bin;
    cnt_t     second_bin;
  } stats_reply_t;

  len_t         lowest_q;
  len_t         highest_q;
  value_stats_t value_stats [2];
  cnt_t         length_hist [2][BINS];
  stats_reply_t expected_replies [$];
  int           fails = 0;

  function automatic void clear_statistics();
    for (int v = 0; v < 2; v++) begin
      value_stats[v].tally = '0;
      value_stats[v].low = LOW_RESET;
      value_stats[v].high = '0;
      value_stats[v].sum = '0;
      value_stats[v].delta_high = '0;
    end
    for (int h = 0; h < 2; h++) begin
      for (int b = 0; b < BINS; b++) begin
        length_hist[h][b] = '0;
      end
    end
  endfunction

  function automatic int length_bin(len_t length);
    len_t        clamped;
    int unsigned offset;
    if (length <= lowest_q) return 0;
    clamped = (length > highest_q) ? highest_q : length;
    if (clamped < lowest_q) return 0;
    offset = int'(clamped) - int'(lowest_q);
    if (offset > BINS - 1) return BINS - 1;
    return int'(offset);
  endfunction

  function automatic void record_half_bit(logic half, logic value, len_t length, len_t delta);
    int v;
    v = value ? 1 : 0;
    value_stats[v].tally = value_stats[v].tally + 1'b1;
    if (length > value_stats[v].high) value_stats[v].high = length;
    if (length < value_stats[v].low) value_stats[v].low = length;
    value_stats[v].sum = value_stats[v].sum + cnt_t'(length);
    if (half && delta > value_stats[v].delta_high) value_stats[v].delta_high = delta;
    length_hist[half ? 1 : 0][length_bin(length)] += 1'b1;
  endfunction

  function automatic stats_reply_t build_reply(bsel_t bin);
    stats_reply_t reply;
    reply.summary.zero_count = value_stats[0].tally;
    reply.summary.one_count = value_stats[1].tally;
    reply.summary.zero_min = value_stats[0].low;
    reply.summary.zero_max = value_stats[0].high;
    reply.summary.zero_total = value_stats[0].sum;
    reply.summary.zero_delta_peak = value_stats[0].delta_high;
    reply.summary.one_min = value_stats[1].low;
    reply.summary.one_max = value_stats[1].high;
    reply.summary.one_total = value_stats[1].sum;
    reply.summary.one_delta_peak = value_stats[1].delta_high;
    if (int'(bin) < BINS) begin
      reply.first_bin = length_hist[0][bin];
      reply.second_bin = length_hist[1][bin];
    end else begin
      reply.first_bin = '0;
      reply.second_bin = '0;
    end
    return reply;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i) begin : observe
    stats_reply_t want;
    int           bad;
    if (!rst_ni) begin
      lowest_q = LOWEST_RESET;
      highest_q = HIGHEST_RESET;
      clear_statistics();
      expected_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == REG_LOWEST) begin
          lowest_q = pwdata[LEN_W-1:0];
        end else if ((paddr >> 2) == REG_HIGHEST) begin
          highest_q = pwdata[LEN_W-1:0];
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t result mismatch: expected none, actual zero_count %0d", $time,
                   res_i.zero_count);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          bad = 0;
          bad += field_differs("zero_count", want.summary.zero_count, res_i.zero_count);
          bad += field_differs("one_count", want.summary.one_count, res_i.one_count);
          bad += field_differs("zero_min", want.summary.zero_min, res_i.zero_min);
          bad += field_differs("zero_max", want.summary.zero_max, res_i.zero_max);
          bad += field_differs("zero_total", want.summary.zero_total, res_i.zero_total);
          bad += field_differs("zero_delta_peak", want.summary.zero_delta_peak,
                               res_i.zero_delta_peak);
          bad += field_differs("one_min", want.summary.one_min, res_i.one_min);
          bad += field_differs("one_max", want.summary.one_max, res_i.one_max);
          bad += field_differs("one_total", want.summary.one_total, res_i.one_total);
          bad += field_differs("one_delta_peak", want.summary.one_delta_peak,
                               res_i.one_delta_peak);
          bad += field_differs("first_half_bin", want.first_bin, res_i.first_half_bin);
          bad += field_differs("second_half_bin", want.second_bin, res_i.second_half_bin);
          if (bad != 0) fails++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.kind)
          KIND_RECORD: begin
            record_half_bit(req_i.second_half, req_i.bit_value, req_i.half_length,
                            req_i.half_delta);
          end
          KIND_READ: begin
            expected_replies.push_back(build_reply(req_i.bin_index));
          end
          KIND_SNAPSHOT: begin
            expected_replies.push_back(build_reply(req_i.bin_index));
            clear_statistics();
          end
          default: begin
          end
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_replies.size();
  end

endmodule

>>> dv/tb_half_bit_timing_statistics_unit.sv
// Stimulus and verdict for the half-bit timing statistics unit testbench.
module tb_half_bit_timing_statistics_unit;
  import hbts_pkg::*;

  localparam kind_t KIND_UNUSED    = 2'd3;
  localparam int    SETTLE_CYCLES  = 140;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    PHASES         = 10;
  localparam int    PHASE_ITEMS    = 143;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  psel;
  logic  penable;
  logic  pwrite;
  addr_t paddr;
  data_t pwdata;
  data_t prdata;
  logic  pready;
  logic  idle_en;
  int    ready_hold = 0;
  int    fail_count;
  int    pending;
  len_t  cur_lowest;
  len_t  cur_highest;

  len_t window_low  [8] = '{16'd45, 16'd0, 16'd65535, 16'd200, 16'd0, 16'd65535, 16'd0, 16'd30};
  len_t window_high [8] = '{16'd150, 16'd65535, 16'd0, 16'd100, 16'd0, 16'd65535, 16'd127,
                            16'd40};

  hbts_req_if req_if ();
  hbts_res_if res_if ();

  half_bit_timing_statistics_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hbts_stats_compare stats_compare (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      res_if.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (psel && penable && pwrite)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL half_bit_timing_statistics_unit");
    $finish;
  end

  task automatic send_event(kind_t kind, logic half, logic value, len_t length, len_t delta,
                            bsel_t bin);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.second_half <= half;
    req_if.bit_value <= value;
    req_if.half_length <= length;
    req_if.half_delta <= delta;
    req_if.bin_index <= bin;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e index, len_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr_t'(index) << 2;
    pwdata <= data_t'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_window(len_t lowest, len_t highest);
    write_reg(REG_LOWEST, lowest);
    write_reg(REG_HIGHEST, highest);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_lowest = lowest;
    cur_highest = highest;
  endtask

  function automatic len_t pick_length();
    int unsigned lo;
    int unsigned hi;
    lo = (cur_lowest < cur_highest) ? cur_lowest : cur_highest;
    hi = (cur_lowest < cur_highest) ? cur_highest : cur_lowest;
    lo = (lo > 8) ? lo - 8 : 0;
    hi = (hi < 65527) ? hi + 8 : 65535;
    if (hi - lo > 300) hi = lo + 300;
    case ($urandom_range(0, 9))
      0: return len_t'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2: return cur_lowest;
      3: return cur_highest;
      default: return len_t'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic send_random_event();
    int unsigned span;
    int unsigned choice;
    kind_t       kind;
    bsel_t       bin;
    len_t        delta;
    choice = $urandom_range(0, 99);
    if (choice < 70) kind = KIND_RECORD;
    else if (choice < 90) kind = KIND_READ;
    else if (choice < 96) kind = KIND_SNAPSHOT;
    else kind = KIND_UNUSED;
    span = (cur_highest > cur_lowest) ? cur_highest - cur_lowest : 3;
    if (span > BINS - 1) span = BINS - 1;
    bin = $urandom_range(0, 1) ? bsel_t'($urandom_range(0, span))
                               : bsel_t'($urandom_range(0, BINS - 1));
    delta = len_t'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    send_event(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_length(), delta,
               bin);
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_en = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_RECORD;
    req_if.second_half = 1'b0;
    req_if.bit_value = 1'b0;
    req_if.half_length = '0;
    req_if.half_delta = '0;
    req_if.bin_index = '0;
    cur_lowest = LOWEST_RESET;
    cur_highest = HIGHEST_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default window first, starting from empty statistics.
    send_event(KIND_READ, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0);
    send_event(KIND_SNAPSHOT, 1'b0, 1'b0, 16'd0, 16'd0, 7'd127);
    send_event(KIND_RECORD, 1'b0, 1'b0, 16'd0, 16'hFFFF, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 7'd0);
    send_event(KIND_RECORD, 1'b0, 1'b1, 16'd45, 16'd0, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b1, 16'd46, 16'd1, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b1, 16'd150, 16'd7, 7'd0);
    send_event(KIND_RECORD, 1'b0, 1'b0, 16'd151, 16'd0, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b0, 16'd44, 16'd3, 7'd0);
    send_event(KIND_UNUSED, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 7'd127);
    send_event(KIND_READ, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0);
    send_event(KIND_READ, 1'b0, 1'b0, 16'd0, 16'd0, 7'd1);
    send_event(KIND_READ, 1'b0, 1'b0, 16'd0, 16'd0, 7'd105);
    send_event(KIND_READ, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 7'd127);
    send_event(KIND_SNAPSHOT, 1'b0, 1'b0, 16'd0, 16'd0, 7'd105);
    send_event(KIND_READ, 1'b0, 1'b0, 16'd0, 16'd0, 7'd105);
    wait_idle();
    set_window(16'd0, 16'hFFFF);
    send_event(KIND_RECORD, 1'b0, 1'b1, 16'hFFFF, 16'd0, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b0, 16'd200, 16'd0, 7'd0);
    send_event(KIND_RECORD, 1'b0, 1'b1, 16'd0, 16'd0, 7'd0);
    send_event(KIND_READ, 1'b0, 1'b0, 16'd0, 16'd0, 7'd127);
    wait_idle();
    set_window(16'd200, 16'd100);
    send_event(KIND_RECORD, 1'b0, 1'b0, 16'd150, 16'd0, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b0, 16'd201, 16'd9, 7'd0);
    send_event(KIND_RECORD, 1'b1, 1'b1, 16'hFFFF, 16'd5, 7'd0);
    send_event(KIND_SNAPSHOT, 1'b0, 1'b0, 16'd0, 16'd0, 7'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p < 8) begin
        set_window(window_low[p], window_high[p]);
      end else begin
        set_window(len_t'($urandom_range(0, 400)), len_t'($urandom_range(0, 700)));
      end
      if (p == PHASES - 1) idle_en <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_event();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS half_bit_timing_statistics_unit");
    end else begin
      $display("FAIL half_bit_timing_statistics_unit");
    end
    $finish;
  end

endmodule

>>> half_bit_timing_statistics_unit.f
+incdir+design
design/hbts_pkg.sv
design/hbts_ifs.sv
design/hbts_hist.sv
design/hbts_summary.sv
design/half_bit_timing_statistics_unit.sv
dv/hbts_stats_compare.sv
dv/tb_half_bit_timing_statistics_unit.sv
